### sv/camera_frame_crop_and_marker_scan_top_defines.svh
// Assertion helpers shared by the RTL of the camera crop and marker scan block.
`ifndef CAMERA_FRAME_CROP_AND_MARKER_SCAN_TOP_DEFINES_SVH
`define CAMERA_FRAME_CROP_AND_MARKER_SCAN_TOP_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define CFCMS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the following cycle.
`define CFCMS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/cfcms_pkg.sv
package cfcms_pkg;

  localparam int MAX_ROW_BYTES = 1024;
  localparam int MAX_ROWS      = 256;

  localparam int POS_W = $clog2(MAX_ROW_BYTES);    // byte position in a row
  localparam int RB_W  = POS_W + 1;                // row length, holds MAX_ROW_BYTES
  localparam int RC_W  = $clog2(MAX_ROWS) + 1;     // row counter, holds MAX_ROWS

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam logic [7:0] MARKER_PREFIX = 8'hFF;
  localparam logic [7:0] MARKER_SOI    = 8'hD8;
  localparam logic [7:0] MARKER_EOI    = 8'hD9;

  localparam logic [10:0] ROW_BYTES_RST  = 11'd640;
  localparam logic [8:0]  CROP_BYTES_RST = 9'd96;
  localparam logic [6:0]  CROP_ROWS_RST  = 7'd8;
  localparam logic [7:0]  TOTAL_ROWS_RST = 8'd240;

  typedef enum logic [1:0] {
    KIND_JPEG_DATA  = 2'd0,
    KIND_JPEG_START = 2'd1,
    KIND_FRAME_END  = 2'd2,
    KIND_PIXEL      = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REG_CAPTURE_FORMAT = 3'd0,
    REG_ROW_BYTES      = 3'd1,
    REG_CROP_BYTES     = 3'd2,
    REG_CROP_ROWS      = 3'd3,
    REG_TOTAL_ROWS     = 3'd4
  } reg_idx_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  out_byte;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  pixel_row;
    logic [8:0]  pixel_col;
    logic        row_last;
  } result_t;

endpackage

### sv/camera_frame_crop_and_marker_scan_top.sv
// Camera frame crop and marker scan.
// The input takes one camera FIFO word per cycle unless stalled (in_fifo_byte, with
// in_frame_start marking the first byte of a frame, which clears all scan state).
// In raw mode the bytes are cut into rows, cropped at the edges and paired into
// RGB565 pixels that leave on the output channel with their cropped row and column;
// in JPEG mode the block looks for the start marker, forwards the image bytes and
// stops at the end marker. A byte gives at most one output word.
// Throughput is one byte per cycle while in_stall is low: every byte is decoded in
// the cycle it is accepted and its result is registered into the output register,
// or into the skid register when a stalled output word holds the output register.
// The output side has a two-entry buffer (output register plus skid register);
// in_stall is a registered flag that rises only when both entries are full, so a
// stalled receiver costs no bytes and the input keeps flowing while one word waits.
// Reset (rst_n low at a clock edge) empties the buffer, clears the scan state and
// returns the configuration registers to their defaults. The user must write the
// configuration via the APB-style cfg_ port while no byte is in flight (unchecked).
module camera_frame_crop_and_marker_scan_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        in_fifo_byte,
  input  logic                              in_frame_start,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_kind,
  output logic [7:0]                        out_byte,
  output logic [7:0]                        out_red,
  output logic [7:0]                        out_green,
  output logic [7:0]                        out_blue,
  output logic [7:0]                        out_pixel_row,
  output logic [8:0]                        out_pixel_col,
  output logic                              out_row_last,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [cfcms_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [cfcms_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [cfcms_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                              cfg_pready
);
  import cfcms_pkg::*;

  `include "camera_frame_crop_and_marker_scan_top_defines.svh"

  // Configuration registers.
  logic        capture_format_r;
  logic [10:0] row_bytes_r;
  logic [8:0]  crop_bytes_r;
  logic [6:0]  crop_rows_r;
  logic [7:0]  total_rows_r;

  // Scan state.
  logic [7:0]      previous_byte_r, previous_byte_nxt;
  logic [7:0]      high_byte_hold_r, high_byte_hold_nxt;
  logic            in_image_r, in_image_nxt;
  logic            frame_done_r, frame_done_nxt;
  logic [RC_W-1:0] row_count_r, row_count_nxt;
  logic [POS_W-1:0] byte_in_row_r, byte_in_row_nxt;

  // Output buffer.
  result_t out_r, out_nxt;
  result_t skid_r, skid_nxt;
  logic    out_valid_r, out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;

  logic    cfg_wr;
  logic    in_acc;
  logic    res_valid;
  result_t res;

  // State as seen by the current byte: a frame start clears it first.
  logic [7:0]       cur_prev, cur_hold;
  logic             cur_in_image, cur_done;
  logic [RC_W-1:0]  cur_rc, rc_inc;
  logic [POS_W-1:0] cur_bir, pos;

  logic [RB_W-1:0]  rb, row_end;
  logic [POS_W-1:0] off;
  logic [RC_W-1:0]  crop_rows_ext;
  logic [RC_W:0]    rows_sum;
  logic [RC_W-1:0]  row_rel;
  logic [15:0]      px;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_paddr[4:2])
      REG_CAPTURE_FORMAT: cfg_prdata = {{(CFG_DATA_W-1){1'b0}}, capture_format_r};
      REG_ROW_BYTES:      cfg_prdata = {{(CFG_DATA_W-11){1'b0}}, row_bytes_r};
      REG_CROP_BYTES:     cfg_prdata = {{(CFG_DATA_W-9){1'b0}}, crop_bytes_r};
      REG_CROP_ROWS:      cfg_prdata = {{(CFG_DATA_W-7){1'b0}}, crop_rows_r};
      REG_TOTAL_ROWS:     cfg_prdata = {{(CFG_DATA_W-8){1'b0}}, total_rows_r};
      default:            cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capture_format_r <= 1'b0;
      row_bytes_r      <= ROW_BYTES_RST;
      crop_bytes_r     <= CROP_BYTES_RST;
      crop_rows_r      <= CROP_ROWS_RST;
      total_rows_r     <= TOTAL_ROWS_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[4:2])
        REG_CAPTURE_FORMAT: capture_format_r <= cfg_pwdata[0];
        REG_ROW_BYTES:      row_bytes_r      <= cfg_pwdata[10:0];
        REG_CROP_BYTES:     crop_bytes_r     <= cfg_pwdata[8:0];
        REG_CROP_ROWS:      crop_rows_r      <= cfg_pwdata[6:0];
        REG_TOTAL_ROWS:     total_rows_r     <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !in_stall;

  assign cur_prev     = in_frame_start ? 8'd0 : previous_byte_r;
  assign cur_hold     = in_frame_start ? 8'd0 : high_byte_hold_r;
  assign cur_in_image = in_frame_start ? 1'b0 : in_image_r;
  assign cur_done     = in_frame_start ? 1'b0 : frame_done_r;
  assign cur_rc       = in_frame_start ? '0 : row_count_r;
  assign cur_bir      = in_frame_start ? '0 : byte_in_row_r;

  // Row length clamped to the supported range.
  always_comb begin
    if (row_bytes_r < RB_W'(2)) begin
      rb = RB_W'(2);
    end else if (row_bytes_r > RB_W'(MAX_ROW_BYTES)) begin
      rb = RB_W'(MAX_ROW_BYTES);
    end else begin
      rb = row_bytes_r;
    end
  end

  // A position left over from a longer row starts a new row.
  assign pos     = ({1'b0, cur_bir} >= rb) ? '0 : cur_bir;
  assign rc_inc  = (pos == '0 && cur_rc < RC_W'(MAX_ROWS)) ? cur_rc + 1'b1 : cur_rc;
  assign crop_rows_ext = RC_W'(crop_rows_r);
  assign rows_sum = {1'b0, rc_inc} + {1'b0, crop_rows_ext};
  assign row_end  = rb - RB_W'(crop_bytes_r);
  assign off      = pos - POS_W'(crop_bytes_r);
  assign row_rel  = rc_inc - crop_rows_ext - 1'b1;
  assign px       = {cur_hold, in_fifo_byte};

  always_comb begin
    previous_byte_nxt  = in_fifo_byte;
    high_byte_hold_nxt = cur_hold;
    in_image_nxt       = cur_in_image;
    frame_done_nxt     = cur_done;
    row_count_nxt      = cur_rc;
    byte_in_row_nxt    = cur_bir;
    res_valid          = 1'b0;
    res                = '0;
    res.kind           = KIND_JPEG_DATA;

    if (cur_done) begin
      res_valid = 1'b0;
    end else if (capture_format_r) begin
      if (cur_prev == MARKER_PREFIX && in_fifo_byte == MARKER_EOI) begin
        frame_done_nxt = 1'b1;
        res_valid      = 1'b1;
        res.kind       = KIND_FRAME_END;
        res.out_byte   = MARKER_EOI;
      end else if (cur_in_image) begin
        res_valid    = 1'b1;
        res.kind     = KIND_JPEG_DATA;
        res.out_byte = in_fifo_byte;
      end else if (cur_prev == MARKER_PREFIX && in_fifo_byte == MARKER_SOI) begin
        in_image_nxt = 1'b1;
        res_valid    = 1'b1;
        res.kind     = KIND_JPEG_START;
        res.out_byte = MARKER_SOI;
      end
    end else begin
      row_count_nxt   = rc_inc;
      byte_in_row_nxt = ({1'b0, pos} + RB_W'(1) >= rb) ? '0 : pos + 1'b1;
      if (rc_inc <= crop_rows_ext) begin
        res_valid = 1'b0;
      end else if (rows_sum > (RC_W+1)'(total_rows_r)) begin
        frame_done_nxt = 1'b1;
        res_valid      = 1'b1;
        res.kind       = KIND_FRAME_END;
      end else if ({1'b0, crop_bytes_r, 1'b0} >= rb) begin
        // Side crop covers the whole row: rows are counted, nothing is kept.
        res_valid = 1'b0;
      end else if ({1'b0, pos} >= RB_W'(crop_bytes_r) && {1'b0, pos} < row_end) begin
        if (!off[0]) begin
          high_byte_hold_nxt = in_fifo_byte;
        end else begin
          res_valid     = 1'b1;
          res.kind      = KIND_PIXEL;
          res.red       = {px[15:11], 3'b000};
          res.green     = {px[10:5], 2'b00};
          res.blue      = {px[4:0], 3'b000};
          res.pixel_row = row_rel[7:0];
          res.pixel_col = off[POS_W-1:1];
          res.row_last  = ({1'b0, pos} + RB_W'(2) >= row_end);
        end
      end
    end
  end

  // Two-entry output buffer: the skid entry drains first when the output frees up.
  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_nxt       = res;
        out_valid_nxt = in_acc && res_valid;
      end
    end else if (in_acc && res_valid) begin
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      previous_byte_r  <= '0;
      high_byte_hold_r <= '0;
      in_image_r       <= 1'b0;
      frame_done_r     <= 1'b0;
      row_count_r      <= '0;
      byte_in_row_r    <= '0;
      out_valid_r      <= 1'b0;
      skid_valid_r     <= 1'b0;
    end else begin
      if (in_acc) begin
        previous_byte_r  <= previous_byte_nxt;
        high_byte_hold_r <= high_byte_hold_nxt;
        in_image_r       <= in_image_nxt;
        frame_done_r     <= frame_done_nxt;
        row_count_r      <= row_count_nxt;
        byte_in_row_r    <= byte_in_row_nxt;
      end
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_r.kind;
  assign out_byte      = out_r.out_byte;
  assign out_red       = out_r.red;
  assign out_green     = out_r.green;
  assign out_blue      = out_r.blue;
  assign out_pixel_row = out_r.pixel_row;
  assign out_pixel_col = out_r.pixel_col;
  assign out_row_last  = out_r.row_last;

  `CFCMS_ASSERT_IMP(a_skid_behind_out, skid_valid_r, out_valid_r,
    "skid entry holds a word while the output register is empty")
  `CFCMS_ASSERT_IMP(a_skid_fill_on_stall, $rose(skid_valid_r), $past(out_valid_r && out_stall),
    "skid entry filled without a stalled output word")
  `CFCMS_ASSERT_IMP(a_done_is_silent, in_acc && frame_done_r && !in_frame_start, !res_valid,
    "result produced after the frame ended")
  `CFCMS_ASSERT_NEXT(a_jpeg_no_row_count, in_acc && capture_format_r && !in_frame_start,
    row_count_r == $past(row_count_r),
    "row counter moved on a JPEG mode byte")

endmodule

### tb/tb_camera_frame_crop_and_marker_scan_top.sv
module tb_camera_frame_crop_and_marker_scan_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cfcms_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 7;
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_WORDS   = 1100;
  localparam int FRAME_CAP      = 200;
  localparam logic [2:0] UNMAPPED_REG = 3'd5;

  // How a word's result is checked: ROW_CFG marks a register write in the directed table.
  typedef enum logic [1:0] {
    ROW_CFG    = 2'd0,
    ROW_MODEL  = 2'd1,
    ROW_NONE   = 2'd2,
    ROW_RESULT = 2'd3
  } dir_op_t;

  typedef struct packed {
    dir_op_t     op;
    logic [2:0]  reg_sel;
    logic [10:0] value;
    logic        fs;
    kind_t       kind;
    logic [7:0]  ob;
  } dir_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       fs;
    dir_op_t    chk;
    kind_t      kind;
    logic [7:0] ob;
  } camera_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_fifo_byte = 8'h00;
  logic                  in_frame_start = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            out_kind;
  logic [7:0]            out_byte;
  logic [7:0]            out_red;
  logic [7:0]            out_green;
  logic [7:0]            out_blue;
  logic [7:0]            out_pixel_row;
  logic [8:0]            out_pixel_col;
  logic                  out_row_last;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  camera_frame_crop_and_marker_scan_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_fifo_byte   (in_fifo_byte),
    .in_frame_start (in_frame_start),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_byte       (out_byte),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_pixel_row  (out_pixel_row),
    .out_pixel_col  (out_pixel_col),
    .out_row_last   (out_row_last),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Register copies, updated when a write completes.
  logic        capture_fmt    = 1'b0;
  logic [10:0] row_len_cfg    = ROW_BYTES_RST;
  logic [8:0]  side_crop_cfg  = CROP_BYTES_RST;
  logic [6:0]  edge_rows_cfg  = CROP_ROWS_RST;
  logic [7:0]  frame_rows_cfg = TOTAL_ROWS_RST;

  // Scan state of the predictor.
  logic [7:0]       last_byte  = '0;
  logic [7:0]       pixel_hi   = '0;
  logic             soi_seen   = 1'b0;
  logic             frame_over = 1'b0;
  logic [RC_W-1:0]  row_num    = '0;
  logic [POS_W-1:0] row_pos    = '0;

  camera_word_t camera_bytes_q[$];
  result_t      scan_results_q[$];
  camera_word_t cur_word = '0;

  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;
  int mismatches     = 0;
  int words_made     = 0;

  dir_row_t dir_tab [26] = '{
    // Reset state, raw mode with the default crop: the first row is skipped.
    '{ROW_NONE,   REG_CAPTURE_FORMAT, 11'h000, 1'b1, KIND_JPEG_DATA,  8'h00},
    '{ROW_NONE,   REG_CAPTURE_FORMAT, 11'h0FF, 1'b0, KIND_JPEG_DATA,  8'h00},
    '{ROW_CFG,    REG_CAPTURE_FORMAT, 11'd1,   1'b0, KIND_JPEG_DATA,  8'h00},
    // End marker with no start marker still closes the frame.
    '{ROW_NONE,   REG_CAPTURE_FORMAT, 11'h012, 1'b1, KIND_JPEG_DATA,  8'h00},
    '{ROW_NONE,   REG_CAPTURE_FORMAT, 11'h0FF, 1'b0, KIND_JPEG_DATA,  8'h00},
    '{ROW_RESULT, REG_CAPTURE_FORMAT, 11'h0D9, 1'b0, KIND_FRAME_END,  8'hD9},
    '{ROW_NONE,   REG_CAPTURE_FORMAT, 11'h055, 1'b0, KIND_JPEG_DATA,  8'h00},
    // A start marker inside the image is plain data.
    '{ROW_NONE,   REG_CAPTURE_FORMAT, 11'h0FF, 1'b1, KIND_JPEG_DATA,  8'h00},
    '{ROW_RESULT, REG_CAPTURE_FORMAT, 11'h0D8, 1'b0, KIND_JPEG_START, 8'hD8},
    '{ROW_RESULT, REG_CAPTURE_FORMAT, 11'h000, 1'b0, KIND_JPEG_DATA,  8'h00},
    '{ROW_RESULT, REG_CAPTURE_FORMAT, 11'h0FF, 1'b0, KIND_JPEG_DATA,  8'hFF},
    '{ROW_RESULT, REG_CAPTURE_FORMAT, 11'h0D8, 1'b0, KIND_JPEG_DATA,  8'hD8},
    '{ROW_RESULT, REG_CAPTURE_FORMAT, 11'h0FF, 1'b0, KIND_JPEG_DATA,  8'hFF},
    '{ROW_RESULT, REG_CAPTURE_FORMAT, 11'h0D9, 1'b0, KIND_FRAME_END,  8'hD9},
    '{ROW_CFG,    REG_CAPTURE_FORMAT, 11'd0,   1'b0, KIND_JPEG_DATA,  8'h00},
    '{ROW_CFG,    REG_ROW_BYTES,      11'd6,   1'b0, KIND_JPEG_DATA,  8'h00},
    '{ROW_CFG,    REG_CROP_BYTES,     11'd1,   1'b0, KIND_JPEG_DATA,  8'h00},
    '{ROW_CFG,    REG_CROP_ROWS,      11'd0,   1'b0, KIND_JPEG_DATA,  8'h00},
    '{ROW_CFG,    REG_TOTAL_ROWS,     11'd1,   1'b0, KIND_JPEG_DATA,  8'h00},
    // One kept row of two pixels, all ones then all zeros, then the frame end.
    '{ROW_NONE,   REG_CAPTURE_FORMAT, 11'h000, 1'b1, KIND_JPEG_DATA,  8'h00},
    '{ROW_NONE,   REG_CAPTURE_FORMAT, 11'h0FF, 1'b0, KIND_JPEG_DATA,  8'h00},
    '{ROW_MODEL,  REG_CAPTURE_FORMAT, 11'h0FF, 1'b0, KIND_JPEG_DATA,  8'h00},
    '{ROW_NONE,   REG_CAPTURE_FORMAT, 11'h000, 1'b0, KIND_JPEG_DATA,  8'h00},
    '{ROW_MODEL,  REG_CAPTURE_FORMAT, 11'h000, 1'b0, KIND_JPEG_DATA,  8'h00},
    '{ROW_NONE,   REG_CAPTURE_FORMAT, 11'h0AA, 1'b0, KIND_JPEG_DATA,  8'h00},
    '{ROW_RESULT, REG_CAPTURE_FORMAT, 11'h055, 1'b0, KIND_FRAME_END,  8'h00}
  };

  function automatic int clamp_row_len(input int len);
    if (len < 2) return 2;
    if (len > MAX_ROW_BYTES) return MAX_ROW_BYTES;
    return len;
  endfunction

  function automatic bit crop_scan_predict(input logic [7:0] b, input logic fs,
                                           output result_t r);
    logic [7:0]  prev;
    logic [15:0] px;
    int rb, pos, span_end, off, cb, cr;
    r = '0;
    cb = int'(side_crop_cfg);
    cr = int'(edge_rows_cfg);
    if (fs) begin
      last_byte = '0;
      pixel_hi = '0;
      soi_seen = 1'b0;
      frame_over = 1'b0;
      row_num = '0;
      row_pos = '0;
    end
    prev = last_byte;
    last_byte = b;
    if (frame_over) return 1'b0;
    if (capture_fmt) begin
      if (prev == MARKER_PREFIX && b == MARKER_EOI) begin
        frame_over = 1'b1;
        r.kind = KIND_FRAME_END;
        r.out_byte = MARKER_EOI;
        return 1'b1;
      end
      if (soi_seen) begin
        r.kind = KIND_JPEG_DATA;
        r.out_byte = b;
        return 1'b1;
      end
      if (prev == MARKER_PREFIX && b == MARKER_SOI) begin
        soi_seen = 1'b1;
        r.kind = KIND_JPEG_START;
        r.out_byte = MARKER_SOI;
        return 1'b1;
      end
      return 1'b0;
    end
    rb = clamp_row_len(int'(row_len_cfg));
    // A shorter row length taking effect mid-row starts a new row here.
    if (int'(row_pos) >= rb) row_pos = '0;
    if (row_pos == '0 && row_num < MAX_ROWS) row_num = row_num + 1'b1;
    pos = int'(row_pos);
    row_pos = POS_W'((pos + 1 >= rb) ? 0 : pos + 1);
    if (int'(row_num) <= cr) return 1'b0;
    if (int'(row_num) + cr > int'(frame_rows_cfg)) begin
      frame_over = 1'b1;
      r.kind = KIND_FRAME_END;
      return 1'b1;
    end
    if (2 * cb >= rb) return 1'b0;
    span_end = rb - cb;
    if (pos < cb || pos >= span_end) return 1'b0;
    off = pos - cb;
    if (off % 2 == 0) begin
      pixel_hi = b;
      return 1'b0;
    end
    px = {pixel_hi, b};
    r.kind = KIND_PIXEL;
    r.red = {px[15:11], 3'b000};
    r.green = {px[10:5], 2'b00};
    r.blue = {px[4:0], 3'b000};
    r.pixel_row = 8'(int'(row_num) - cr - 1);
    r.pixel_col = 9'(off / 2);
    r.row_last = (pos + 2 >= span_end);
    return 1'b1;
  endfunction

  function automatic logic [7:0] camera_byte(input bit jpeg);
    case ($urandom_range(0, 7))
      0: return MARKER_PREFIX;
      1: return jpeg ? MARKER_PREFIX : 8'h00;
      2: return jpeg ? MARKER_SOI : 8'hFF;
      3: return jpeg ? MARKER_EOI : 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_word(input logic [7:0] data, input logic fs, input dir_op_t chk,
                           input kind_t kind, input logic [7:0] ob);
    camera_word_t w;
    w.data = data;
    w.fs = fs;
    w.chk = chk;
    w.kind = kind;
    w.ob = ob;
    camera_bytes_q.push_back(w);
    words_made++;
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [10:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      REG_CAPTURE_FORMAT: capture_fmt = value[0];
      REG_ROW_BYTES:      row_len_cfg = value;
      REG_CROP_BYTES:     side_crop_cfg = value[8:0];
      REG_CROP_ROWS:      edge_rows_cfg = value[6:0];
      REG_TOTAL_ROWS:     frame_rows_cfg = value[7:0];
      default: ;
    endcase
  endtask

  // Returns at a falling edge once every word is taken and every result has come back.
  task automatic wait_drained();
    @(negedge clk);
    while (camera_bytes_q.size() != 0 || in_valid || scan_results_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : sender
    result_t      predicted;
    bit           produced;
    camera_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        produced = crop_scan_predict(in_fifo_byte, in_frame_start, predicted);
        if (cur_word.chk == ROW_RESULT) begin
          predicted = '0;
          predicted.kind = cur_word.kind;
          predicted.out_byte = cur_word.ob;
          scan_results_q.push_back(predicted);
        end else if (cur_word.chk == ROW_MODEL && produced) begin
          scan_results_q.push_back(predicted);
        end
      end
      if (!in_valid || !in_stall) begin
        if (camera_bytes_q.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          w = camera_bytes_q.pop_front();
          in_valid <= 1'b1;
          in_fifo_byte <= w.data;
          in_frame_start <= w.fs;
          cur_word <= w;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : receiver
    result_t want;
    int      hold_left;
    int      hold_served;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
      hold_served = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (scan_results_q.size() == 0) begin
          $error("word with no expectation: kind %0d, out_byte %0d", out_kind, out_byte);
          mismatches++;
        end else begin
          want = scan_results_q.pop_front();
          check_field("kind", int'(want.kind), int'(out_kind));
          check_field("out_byte", int'(want.out_byte), int'(out_byte));
          check_field("red", int'(want.red), int'(out_red));
          check_field("green", int'(want.green), int'(out_green));
          check_field("blue", int'(want.blue), int'(out_blue));
          check_field("pixel_row", int'(want.pixel_row), int'(out_pixel_row));
          check_field("pixel_col", int'(want.pixel_col), int'(out_pixel_col));
          check_field("row_last", int'(want.row_last), int'(out_row_last));
        end
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    int quiet;
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet = 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("tb_camera_frame_crop_and_marker_scan_top: FAIL");
      $finish;
    end else begin
      quiet++;
    end
  end

  initial begin
    logic [7:0]  frame_q[$];
    logic        fmt_w;
    logic [10:0] rb_w;
    logic [8:0]  cb_w;
    logic [6:0]  cr_w;
    logic [7:0]  tr_w;
    logic        fs0;
    bit          special;
    int phase, budget, made, len, rbc, end_row, full_len, shape;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].op == ROW_CFG) begin
        wait_drained();
        cfg_write(dir_tab[i].reg_sel, dir_tab[i].value);
        @(negedge clk);
      end else begin
        push_word(dir_tab[i].value[7:0], dir_tab[i].fs, dir_tab[i].op, dir_tab[i].kind,
                  dir_tab[i].ob);
      end
    end
    wait_drained();

    phase = 0;
    made = 0;
    while (made < RANDOM_WORDS) begin
      // Phase 2 is one full-width row that fills the pixel columns, phase 5 one tall frame.
      special = (phase == 2 || phase == 5);
      case (special ? 0 : phase % 4)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 62; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 62; end
        default: begin send_gap_pct = 14; recv_stall_pct = 14; end
      endcase
      if (phase == 2) begin
        fmt_w = 1'b0; rb_w = 11'd2047; cb_w = 9'd0; cr_w = 7'd0; tr_w = 8'd1;
      end else if (phase == 5) begin
        fmt_w = 1'b0; rb_w = 11'd1; cb_w = 9'd0; cr_w = 7'd127; tr_w = 8'd255;
      end else begin
        fmt_w = ($urandom_range(0, 9) < 3);
        case ($urandom_range(0, 9))
          0: rb_w = 11'($urandom_range(0, 1));
          1: rb_w = 11'd2;
          default: rb_w = 11'($urandom_range(3, 20));
        endcase
        cb_w = ($urandom_range(0, 9) == 0) ? 9'd511 : 9'($urandom_range(0, 6));
        cr_w = ($urandom_range(0, 9) == 0) ? 7'd127 : 7'($urandom_range(0, 4));
        case ($urandom_range(0, 9))
          0: tr_w = 8'd0;
          1: tr_w = 8'd255;
          default: tr_w = 8'($urandom_range(1, 8));
        endcase
      end
      cfg_write(REG_CAPTURE_FORMAT, {10'd0, fmt_w});
      cfg_write(REG_ROW_BYTES, rb_w);
      cfg_write(REG_CROP_BYTES, {2'd0, cb_w});
      cfg_write(REG_CROP_ROWS, {4'd0, cr_w});
      cfg_write(REG_TOTAL_ROWS, {3'd0, tr_w});
      if (phase == 3) cfg_write(UNMAPPED_REG, 11'($urandom_range(0, 2047)));
      @(negedge clk);
      if (phase == 2) hold_requests++;

      rbc = clamp_row_len(int'(rb_w));
      end_row = (int'(cr_w) + 1 > int'(tr_w) - int'(cr_w) + 1) ? int'(cr_w) + 1
                                                                : int'(tr_w) - int'(cr_w) + 1;
      full_len = (end_row - 1) * rbc + 1;
      budget = special ? 1 : 80;
      len = 0;
      while (len < budget) begin
        frame_q.delete();
        // A frame usually opens with a frame start; without one the old state carries over.
        fs0 = special || ($urandom_range(0, 7) != 0);
        shape = special ? 9 : $urandom_range(0, 9);
        if (fmt_w) begin
          repeat ($urandom_range(0, 4)) frame_q.push_back(camera_byte(1'b1));
          if (shape != 0) begin
            frame_q.push_back(MARKER_PREFIX);
            frame_q.push_back(MARKER_SOI);
          end
          repeat ($urandom_range(0, 24)) frame_q.push_back(camera_byte(1'b1));
          if (shape != 1) begin
            frame_q.push_back(MARKER_PREFIX);
            frame_q.push_back(MARKER_EOI);
          end
          repeat ($urandom_range(0, 2)) frame_q.push_back(camera_byte(1'b1));
        end else begin
          if (!special && (shape == 0 || full_len > FRAME_CAP))
            repeat ($urandom_range(1, (full_len > FRAME_CAP) ? FRAME_CAP : full_len))
              frame_q.push_back(camera_byte(1'b0));
          else if (shape == 1)
            repeat ($urandom_range(1, 8)) frame_q.push_back(camera_byte(1'b0));
          else
            repeat (full_len + (special ? 2 : $urandom_range(0, 3)))
              frame_q.push_back(camera_byte(1'b0));
        end
        foreach (frame_q[k])
          push_word(frame_q[k], (k == 0) ? fs0 : (shape == 1 && $urandom_range(0, 3) == 0),
                    ROW_MODEL, KIND_JPEG_DATA, 8'h00);
        len += (frame_q.size() == 0) ? 1 : frame_q.size();
        if (!special) made += frame_q.size();
      end
      wait_drained();
      phase++;
    end

    if (mismatches == 0) begin
      $display("tb_camera_frame_crop_and_marker_scan_top: PASS");
    end else begin
      $display("tb_camera_frame_crop_and_marker_scan_top: FAIL");
    end
    $finish;
  end

endmodule
